FILE: rtl/gwhs_pkg.sv
package gwhs_pkg;

    // History and field geometry
    localparam int HIST_DEPTH = 8;
    localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int DATA_W     = 13;
    localparam int CFG_W      = 16;
    localparam int OUT_W      = 21;
    localparam int OUT_FRAC   = 8;

    // Weights are unsigned Q1.16
    localparam int WGT_FRAC = 16;
    localparam int WGT_W    = WGT_FRAC + 1;
    localparam logic [WGT_W-1:0] WEIGHT_ONE   = WGT_W'(1) << WGT_FRAC;
    localparam logic [CFG_W-1:0] WEIGHT_RESET = CFG_W'(13107);

    // Accumulator widths
    localparam int SUMW_W = WGT_W + $clog2(HIST_DEPTH + 1);
    localparam int ACC_W  = DATA_W + SUMW_W;

    // Shared multiplier: 18 x 18 signed
    localparam int MUL_W  = WGT_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Divider widths
    localparam int NUM_W      = ACC_W + OUT_FRAC + 2;
    localparam int DEN_W      = SUMW_W + 1;
    localparam int DIV_CNT_W  = $clog2(OUT_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV_X,
        ST_DIV_Y,
        ST_OUT
    } gwhs_state_t;

    // Sub-steps of one history entry in the accumulate pass
    typedef enum logic [1:0] {
        SUB_MUL_X,
        SUB_ACC_X,
        SUB_ACC_Y,
        SUB_NEXT_W
    } gwhs_sub_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/gwhs_div.sv
module gwhs_div import gwhs_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  num,
    input  logic        [SUMW_W-1:0] den,
    output logic signed [OUT_W-1:0]  quot,
    output div_stat_t                stat
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [DEN_W-1:0]     d_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [OUT_W-1:0]     low_reg;

    logic [ACC_W-1:0]     num_u;
    logic [ACC_W-1:0]     mag;
    logic [NUM_W-1:0]     nfull;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    // Rounded quotient: (|num| * 512 + den) / (2 * den), restoring, one bit a cycle
    always_comb begin
        num_u = unsigned'(num);
        mag   = num[ACC_W-1] ? (~num_u + 1'b1) : num_u;
        nfull = (NUM_W'(mag) << (OUT_FRAC + 1)) + NUM_W'(den);
        trial = {rem_reg, low_reg[OUT_W-1]};
        diff  = trial - {1'b0, d_reg};
        ge    = (trial >= {1'b0, d_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= DIV_CNT_W'(OUT_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[ACC_W-1];
            d_reg   <= {den, 1'b0};
            // quotient is below 2^OUT_W, so the top part starts below the divisor
            rem_reg <= nfull[OUT_W +: DEN_W];
            low_reg <= nfull[OUT_W-1:0];
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_reg <= {low_reg[OUT_W-2:0], ge};
        end
    end

    assign quot      = $signed(neg_reg ? (~low_reg + 1'b1) : low_reg);
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> stat.busy)
        else $error("divider not busy after start");

    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> (rem_reg < d_reg))
        else $error("partial remainder not below divisor");
`endif

endmodule

FILE: rtl/geometric_weighted_history_smoother_unit.sv
// Smooths pointer displacements over the last HIST_DEPTH (8) input pairs, newest first,
// with weights 1, w, w^2, ... (w = weight_modifier, Q0.16, each power truncated to Q0.16;
// reset value 13107, about 0.2). Each result is the weighted sum of the history divided
// by the weight sum, rounded to nearest (ties away from zero), in signed Q.8. One result
// per input. The history resets to zero. The unit takes no new item until the last
// result has moved to the output register: one shared 18x18 multiplier runs four
// steps per history entry, then one bit-serial divider produces x and then y. s_ready
// is high only while idle; a finished result may still wait on m_ready while the next
// item is taken.
// Write weight_modifier only while idle.
module geometric_weighted_history_smoother_unit import gwhs_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic        [CFG_W-1:0]  cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_delta_x,
    input  logic signed [DATA_W-1:0] s_delta_y,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_filtered_x,
    output logic signed [OUT_W-1:0]  m_filtered_y
);

    gwhs_state_t state_reg, state_next;
    gwhs_sub_t   sub_reg;

    logic signed [DATA_W-1:0] hist_x_reg [HIST_DEPTH];
    logic signed [DATA_W-1:0] hist_y_reg [HIST_DEPTH];

    logic        [CFG_W-1:0]  wm_reg;
    logic        [IDX_W-1:0]  idx_reg;
    logic        [WGT_W-1:0]  w_reg;
    logic        [SUMW_W-1:0] sum_w_reg;
    logic signed [ACC_W-1:0]  acc_x_reg;
    logic signed [ACC_W-1:0]  acc_y_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OUT_W-1:0]  res_x_reg;
    logic signed [OUT_W-1:0]  res_y_reg;
    logic                     m_valid_reg;
    logic signed [OUT_W-1:0]  m_filtered_x_reg;
    logic signed [OUT_W-1:0]  m_filtered_y_reg;

    logic                     in_xfer;
    logic                     out_free;
    logic                     step_last;
    logic                     div_start;
    logic signed [ACC_W-1:0]  div_num;
    logic signed [OUT_W-1:0]  div_quot;
    div_stat_t                div_stat;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign step_last = (sub_reg == SUB_NEXT_W) && (idx_reg == IDX_W'(HIST_DEPTH - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_xfer) state_next = ST_ACCUM;
            ST_ACCUM: if (step_last) state_next = ST_DIV_X;
            ST_DIV_X: if (div_stat.done) state_next = ST_DIV_Y;
            ST_DIV_Y: if (div_stat.done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = acc_x_reg;
        mul_a     = MUL_W'(hist_x_reg[idx_reg]);
        case (state_reg)
            ST_ACCUM: begin
                div_start = step_last;
                case (sub_reg)
                    SUB_MUL_X:  mul_a = MUL_W'(hist_x_reg[idx_reg]);
                    SUB_ACC_X:  mul_a = MUL_W'(hist_y_reg[idx_reg]);
                    SUB_ACC_Y:  mul_a = $signed({2'b00, wm_reg});
                    default:    mul_a = MUL_W'(hist_x_reg[idx_reg]);
                endcase
            end
            ST_DIV_X: begin
                div_start = div_stat.done;
                div_num   = acc_y_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign mul_b    = $signed({1'b0, w_reg});
    assign mul_prod = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wm_reg      <= WEIGHT_RESET;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_x_reg[i] <= '0;
                hist_y_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                wm_reg <= cfg_wr_data;
            end
            if (in_xfer) begin
                for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                    hist_x_reg[i] <= hist_x_reg[i-1];
                    hist_y_reg[i] <= hist_y_reg[i-1];
                end
                hist_x_reg[0] <= s_delta_x;
                hist_y_reg[0] <= s_delta_y;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            idx_reg   <= '0;
            sub_reg   <= SUB_MUL_X;
            w_reg     <= WEIGHT_ONE;
            sum_w_reg <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        if (state_reg == ST_ACCUM) begin
            prod_reg <= mul_prod;
            sub_reg  <= gwhs_sub_t'(sub_reg + 2'd1);
            case (sub_reg)
                SUB_ACC_X: acc_x_reg <= acc_x_reg + ACC_W'(prod_reg);
                SUB_ACC_Y: begin
                    acc_y_reg <= acc_y_reg + ACC_W'(prod_reg);
                    sum_w_reg <= sum_w_reg + SUMW_W'(w_reg);
                end
                SUB_NEXT_W: begin
                    // truncate w * ratio back to Q1.16, then advance to the next entry
                    w_reg   <= prod_reg[WGT_FRAC +: WGT_W];
                    idx_reg <= idx_reg + 1'b1;
                end
                default: ;
            endcase
        end
        if (state_reg == ST_DIV_X && div_stat.done) begin
            res_x_reg <= div_quot;
        end
        if (state_reg == ST_DIV_Y && div_stat.done) begin
            res_y_reg <= div_quot;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_filtered_x_reg <= res_x_reg;
            m_filtered_y_reg <= res_y_reg;
        end
    end

    gwhs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (sum_w_reg),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    assign m_valid      = m_valid_reg;
    assign m_filtered_x = m_filtered_x_reg;
    assign m_filtered_y = m_filtered_y_reg;

`ifndef SYNTHESIS
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after a transfer");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_weight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCUM) |-> (w_reg <= WEIGHT_ONE))
        else $error("weight grew above one");

    a_out_from_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result shown outside the output step");
`endif

endmodule
